// File: rtl/vpg_pkg.sv
// ----------------------------------------------------------------------------
// vpg_pkg
// Shared types and codes for the voxel point grouper.
// ----------------------------------------------------------------------------
`default_nettype none

package vpg_pkg;

  // grid bounds; the point payload and result ports are sized for these
  localparam int MAX_GRID_X = 64;
  localparam int MAX_GRID_Y = 64;
  localparam int MAX_GRID_Z = 4;
  localparam int MAX_BATCH  = 2;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  localparam logic [6:0] GRID_X_RST = 7'd64;
  localparam logic [6:0] GRID_Y_RST = 7'd64;
  localparam logic [2:0] GRID_Z_RST = 3'd4;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_RKEY  = 8'b0000_1000,
    S_RHEAD = 8'b0001_0000,
    S_RPT   = 8'b0010_0000,
    S_CLR   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  // point payload as held in the point store
  typedef struct packed {
    logic       batch;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] z;
    logic [2:0] cam;
    logic [6:0] depth;
    logic [6:0] col;
    logic [5:0] row;
  } pt_t;

  typedef struct packed {
    logic       valid;
    pt_t        pt;
    logic       last;
    logic       kept;
    logic       full;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/voxel_point_grouper.sv
// ----------------------------------------------------------------------------
// voxel_point_grouper
// Groups frustum points per voxel and returns them voxel by voxel.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid_i / req_stall_o) carries add, read, clear or
//   no-op items; each item gives exactly one result on the result channel
//   (res_valid_o / res_stall_i). Grid sizes are set over the APB port.
//   An add passes through S_ADD, a read inside a voxel list through S_RPT,
//   and a read that opens a new voxel reads key order, voxel head and point
//   store in turn; no-ops and dropped adds pass through S_FIN. One item is in
//   work at a time. Clear walks the key order list and empties every voxel seen.
//   After reset the voxel table is swept, one entry a cycle, over all
//   MAX_BATCH*MAX_GRID_Z*MAX_GRID_Y*MAX_GRID_X entries (32768 by default);
//   req_stall_o stays high meanwhile. Config writes are taken at any time.
//   A result waits in the output register while res_stall_i is high; the
//   next item is still accepted but its result is held until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_point_grouper #(
  parameter int MAX_POINTS = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // apb
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  wire         req_valid_i,
  output logic        req_stall_o,
  input  wire  [1:0]  req_type_i,
  input  wire         batch_index_i,
  input  wire  [2:0]  camera_index_i,
  input  wire  [6:0]  depth_bin_i,
  input  wire  [5:0]  pixel_row_i,
  input  wire  [6:0]  pixel_col_i,
  input  wire  [15:0] coord_x_i,
  input  wire  [15:0] coord_y_i,
  input  wire  [15:0] coord_z_i,
  // result channel
  output logic        res_valid_o,
  input  wire         res_stall_i,
  output logic        out_valid_o,
  output logic        out_batch_o,
  output logic [5:0]  out_x_o,
  output logic [5:0]  out_y_o,
  output logic [1:0]  out_z_o,
  output logic [2:0]  out_camera_o,
  output logic [6:0]  out_depth_o,
  output logic [6:0]  out_col_o,
  output logic [5:0]  out_row_o,
  output logic        out_last_o,
  output logic        point_kept_o,
  output logic        store_full_o
);

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int CW   = PW + 1;
  localparam int NVOX = vpg_pkg::MAX_BATCH * vpg_pkg::MAX_GRID_Z
                      * vpg_pkg::MAX_GRID_Y * vpg_pkg::MAX_GRID_X;
  localparam int VKW  = $clog2(NVOX);

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } vox_t;

  typedef struct packed {
    logic          has_next;
    logic [PW-1:0] next;
  } link_t;

  // ---------------- configuration ----------------
  logic [6:0] grid_x_q, grid_y_q;
  logic [2:0] grid_z_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= vpg_pkg::GRID_X_RST;
      grid_y_q <= vpg_pkg::GRID_Y_RST;
      grid_z_q <= vpg_pkg::GRID_Z_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        vpg_pkg::REG_GRID_X: grid_x_q <= pwdata[6:0];
        vpg_pkg::REG_GRID_Y: grid_y_q <= pwdata[6:0];
        vpg_pkg::REG_GRID_Z: grid_z_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vpg_pkg::REG_GRID_X: prdata = {25'd0, grid_x_q};
      vpg_pkg::REG_GRID_Y: prdata = {25'd0, grid_y_q};
      vpg_pkg::REG_GRID_Z: prdata = {29'd0, grid_z_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- memories ----------------
  vox_t          vox_mem [NVOX];
  logic          vox_we, vox_re;
  logic [VKW-1:0] vox_waddr, vox_raddr;
  vox_t          vox_wdata, vox_rdata_q;

  logic [VKW-1:0] ko_mem [MAX_POINTS];
  logic          ko_we, ko_re;
  logic [PW-1:0] ko_waddr, ko_raddr;
  logic [VKW-1:0] ko_wdata, ko_rdata_q;

  vpg_pkg::pt_t  dat_mem [MAX_POINTS];
  logic          dat_we, dat_re;
  logic [PW-1:0] dat_waddr, dat_raddr;
  vpg_pkg::pt_t  dat_wdata, dat_rdata_q;

  link_t         lnk_mem [MAX_POINTS];
  logic          lnk_we, lnk_re;
  logic [PW-1:0] lnk_waddr, lnk_raddr;
  link_t         lnk_wdata, lnk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (vox_we) vox_mem[vox_waddr] <= vox_wdata;
    if (vox_re) vox_rdata_q <= vox_mem[vox_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ko_we) ko_mem[ko_waddr] <= ko_wdata;
    if (ko_re) ko_rdata_q <= ko_mem[ko_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) dat_mem[dat_waddr] <= dat_wdata;
    if (dat_re) dat_rdata_q <= dat_mem[dat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) lnk_mem[lnk_waddr] <= lnk_wdata;
    if (lnk_re) lnk_rdata_q <= lnk_mem[lnk_raddr];
  end

  // ---------------- grid check and key ----------------
  logic [15:0] lim_x, lim_y, lim_z;
  logic        in_grid, store_is_full;
  logic [31:0] key_w;

  assign lim_x = (16'(grid_x_q) < 16'(vpg_pkg::MAX_GRID_X)) ? 16'(grid_x_q)
                                                            : 16'(vpg_pkg::MAX_GRID_X);
  assign lim_y = (16'(grid_y_q) < 16'(vpg_pkg::MAX_GRID_Y)) ? 16'(grid_y_q)
                                                            : 16'(vpg_pkg::MAX_GRID_Y);
  assign lim_z = (16'(grid_z_q) < 16'(vpg_pkg::MAX_GRID_Z)) ? 16'(grid_z_q)
                                                            : 16'(vpg_pkg::MAX_GRID_Z);

  assign in_grid = ({31'd0, batch_index_i} < 32'(vpg_pkg::MAX_BATCH))
                 && !coord_x_i[15] && (coord_x_i < lim_x)
                 && !coord_y_i[15] && (coord_y_i < lim_y)
                 && !coord_z_i[15] && (coord_z_i < lim_z);

  assign key_w = ((({31'd0, batch_index_i} * 32'(vpg_pkg::MAX_GRID_Z) + 32'(coord_z_i))
                 * 32'(vpg_pkg::MAX_GRID_Y) + 32'(coord_y_i)) * 32'(vpg_pkg::MAX_GRID_X))
                 + 32'(coord_x_i);

  // ---------------- control ----------------
  vpg_pkg::state_e state_q, state_d;
  logic [VKW-1:0] init_q, init_d;
  logic [VKW-1:0] key_q, key_d;
  logic [CW-1:0]  pc_q, pc_d, kc_q, kc_d, dkp_q, dkp_d, ci_q, ci_d;
  logic [PW-1:0]  cur_q, cur_d;
  logic           cur_valid_q, cur_valid_d;
  logic           clr_pend_q, clr_pend_d;
  logic           pend_full_q, pend_full_d;
  vpg_pkg::res_t  res_q, res_d;
  logic           res_valid_q, res_load, res_ok, accept;
  logic [CW-1:0]  dkp_inc;

  assign accept        = req_valid_i && (state_q == vpg_pkg::S_IDLE);
  assign res_ok        = !res_valid_q || !res_stall_i;
  assign dkp_inc       = dkp_q + CW'(1);
  assign store_is_full = pc_q >= CW'(MAX_POINTS);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    key_d       = key_q;
    pc_d        = pc_q;
    kc_d        = kc_q;
    dkp_d       = dkp_q;
    ci_d        = ci_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    clr_pend_d  = clr_pend_q;
    pend_full_d = pend_full_q;
    res_d       = '0;
    res_load    = 1'b0;
    vox_we = 1'b0; vox_re = 1'b0; vox_waddr = '0; vox_raddr = '0; vox_wdata = '0;
    ko_we  = 1'b0; ko_re  = 1'b0; ko_waddr  = '0; ko_raddr  = '0; ko_wdata  = '0;
    dat_we = 1'b0; dat_re = 1'b0; dat_waddr = '0; dat_raddr = '0; dat_wdata = '0;
    lnk_we = 1'b0; lnk_re = 1'b0; lnk_waddr = '0; lnk_raddr = '0; lnk_wdata = '0;

    unique case (state_q)
      vpg_pkg::S_INIT: begin
        vox_we    = 1'b1;
        vox_waddr = init_q;
        init_d    = init_q + VKW'(1);
        if (init_q == VKW'(NVOX - 1)) state_d = vpg_pkg::S_IDLE;
      end

      vpg_pkg::S_IDLE: begin
        if (accept) begin
          pend_full_d = 1'b0;
          unique case (vpg_pkg::req_e'(req_type_i))
            vpg_pkg::REQ_ADD: begin
              if (in_grid && !store_is_full) begin
                dat_we    = 1'b1;
                dat_waddr = pc_q[PW-1:0];
                dat_wdata = '{batch: batch_index_i, x: coord_x_i[5:0],
                              y: coord_y_i[5:0], z: coord_z_i[1:0],
                              cam: camera_index_i, depth: depth_bin_i,
                              col: pixel_col_i, row: pixel_row_i};
                lnk_we    = 1'b1;
                lnk_waddr = pc_q[PW-1:0];
                vox_re    = 1'b1;
                vox_raddr = key_w[VKW-1:0];
                key_d     = key_w[VKW-1:0];
                state_d   = vpg_pkg::S_ADD;
              end else begin
                pend_full_d = in_grid;
                state_d     = vpg_pkg::S_FIN;
              end
            end
            vpg_pkg::REQ_READ: begin
              if (cur_valid_q) begin
                dat_re    = 1'b1;
                dat_raddr = cur_q;
                lnk_re    = 1'b1;
                lnk_raddr = cur_q;
                state_d   = vpg_pkg::S_RPT;
              end else if (dkp_q >= kc_q) begin
                state_d = vpg_pkg::S_FIN;
              end else begin
                ko_re    = 1'b1;
                ko_raddr = dkp_q[PW-1:0];
                state_d  = vpg_pkg::S_RKEY;
              end
            end
            vpg_pkg::REQ_CLEAR: begin
              ci_d       = '0;
              clr_pend_d = 1'b0;
              state_d    = vpg_pkg::S_CLR;
            end
            default: state_d = vpg_pkg::S_FIN;
          endcase
        end
      end

      vpg_pkg::S_ADD: begin
        if (res_ok) begin
          vox_we    = 1'b1;
          vox_waddr = key_q;
          if (!vox_rdata_q.valid) begin
            vox_wdata = '{valid: 1'b1, head: pc_q[PW-1:0], tail: pc_q[PW-1:0]};
            if (kc_q < CW'(MAX_POINTS)) begin
              ko_we    = 1'b1;
              ko_waddr = kc_q[PW-1:0];
              ko_wdata = key_q;
              kc_d     = kc_q + CW'(1);
            end
          end else begin
            vox_wdata = '{valid: 1'b1, head: vox_rdata_q.head, tail: pc_q[PW-1:0]};
            lnk_we    = 1'b1;
            lnk_waddr = vox_rdata_q.tail;
            lnk_wdata = '{has_next: 1'b1, next: pc_q[PW-1:0]};
          end
          pc_d       = pc_q + CW'(1);
          res_d.kept = 1'b1;
          res_load   = 1'b1;
          state_d    = vpg_pkg::S_IDLE;
        end
      end

      vpg_pkg::S_RKEY: begin
        vox_re    = 1'b1;
        vox_raddr = ko_rdata_q;
        state_d   = vpg_pkg::S_RHEAD;
      end

      vpg_pkg::S_RHEAD: begin
        cur_d     = vox_rdata_q.head;
        dat_re    = 1'b1;
        dat_raddr = vox_rdata_q.head;
        lnk_re    = 1'b1;
        lnk_raddr = vox_rdata_q.head;
        state_d   = vpg_pkg::S_RPT;
      end

      vpg_pkg::S_RPT: begin
        if (res_ok) begin
          res_d.valid = 1'b1;
          res_d.pt    = dat_rdata_q;
          if (lnk_rdata_q.has_next) begin
            cur_d       = lnk_rdata_q.next;
            cur_valid_d = 1'b1;
          end else begin
            cur_valid_d = 1'b0;
            dkp_d       = dkp_inc;
            res_d.last  = dkp_inc >= kc_q;
          end
          res_load = 1'b1;
          state_d  = vpg_pkg::S_IDLE;
        end
      end

      vpg_pkg::S_CLR: begin
        // key order entry is read, and that voxel is emptied in the cycle after
        if (clr_pend_q) begin
          vox_we    = 1'b1;
          vox_waddr = ko_rdata_q;
        end
        if (ci_q < kc_q) begin
          ko_re      = 1'b1;
          ko_raddr   = ci_q[PW-1:0];
          ci_d       = ci_q + CW'(1);
          clr_pend_d = 1'b1;
        end else begin
          clr_pend_d = 1'b0;
          if (!clr_pend_q) begin
            pc_d        = '0;
            kc_d        = '0;
            dkp_d       = '0;
            cur_valid_d = 1'b0;
            state_d     = vpg_pkg::S_FIN;
          end
        end
      end

      vpg_pkg::S_FIN: begin
        if (res_ok) begin
          res_d.full = pend_full_q;
          res_load   = 1'b1;
          state_d    = vpg_pkg::S_IDLE;
        end
      end

      default: state_d = vpg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpg_pkg::S_INIT;
      init_q      <= '0;
      pc_q        <= '0;
      kc_q        <= '0;
      dkp_q       <= '0;
      ci_q        <= '0;
      cur_valid_q <= 1'b0;
      clr_pend_q  <= 1'b0;
      pend_full_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      pc_q        <= pc_d;
      kc_q        <= kc_d;
      dkp_q       <= dkp_d;
      ci_q        <= ci_d;
      cur_valid_q <= cur_valid_d;
      clr_pend_q  <= clr_pend_d;
      pend_full_q <= pend_full_d;
      res_valid_q <= res_load | (res_valid_q & res_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cur_q <= cur_d;
    if (res_load) res_q <= res_d;
  end

  assign req_stall_o  = (state_q != vpg_pkg::S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = res_q.valid;
  assign out_batch_o  = res_q.pt.batch;
  assign out_x_o      = res_q.pt.x;
  assign out_y_o      = res_q.pt.y;
  assign out_z_o      = res_q.pt.z;
  assign out_camera_o = res_q.pt.cam;
  assign out_depth_o  = res_q.pt.depth;
  assign out_col_o    = res_q.pt.col;
  assign out_row_o    = res_q.pt.row;
  assign out_last_o   = res_q.last;
  assign point_kept_o = res_q.kept;
  assign store_full_o = res_q.full;

endmodule

`default_nettype wire

// File: rtl/vpg_checker.sv
// ----------------------------------------------------------------------------
// vpg_checker
// Port-level checks for the voxel point grouper.
// ----------------------------------------------------------------------------
`default_nettype none

module vpg_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       req_valid_i,
  input wire       req_stall_o,
  input wire       res_valid_o,
  input wire       res_stall_i,
  input wire       out_valid_o,
  input wire       out_last_o,
  input wire       point_kept_o,
  input wire       store_full_o,
  input wire [5:0] out_x_o,
  input wire [5:0] out_row_o
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> req_stall_o)
    else $error("request accepted while previous item in work");

  a_last_has_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_last_o) |-> out_valid_o)
    else $error("last flag without a returned point");

  a_add_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (point_kept_o || store_full_o)) |->
      (!out_valid_o && !(point_kept_o && store_full_o)))
    else $error("add flags inconsistent");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_stall_i) |=>
      (res_valid_o && $stable(out_x_o) && $stable(out_row_o) && $stable(out_valid_o)))
    else $error("stalled result changed");

endmodule

bind voxel_point_grouper vpg_checker u_vpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_valid_i),
  .req_stall_o  (req_stall_o),
  .res_valid_o  (res_valid_o),
  .res_stall_i  (res_stall_i),
  .out_valid_o  (out_valid_o),
  .out_last_o   (out_last_o),
  .point_kept_o (point_kept_o),
  .store_full_o (store_full_o),
  .out_x_o      (out_x_o),
  .out_row_o    (out_row_o)
);

`default_nettype wire

// File: tb/sv/voxel_point_grouper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_point_grouper_tb
// Self-checking bench for the voxel point grouper. Adds, reads, clears and
// no-ops go in over the request channel under random idling on both sides.
// A scoreboard predicts each result from its own copy of the grid registers,
// voxel lists and key order, and checks every result in order.
// ----------------------------------------------------------------------------

module voxel_point_grouper_tb;

  typedef struct {
    vpg_pkg::req_e rq;
    logic        b;
    logic [2:0]  cam;
    logic [6:0]  dep;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
  } point_req_t;

  class grouper_scoreboard;
    logic [6:0]  gx = vpg_pkg::GRID_X_RST;
    logic [6:0]  gy = vpg_pkg::GRID_Y_RST;
    logic [2:0]  gz = vpg_pkg::GRID_Z_RST;
    bit          head_ok [32768];
    logic [11:0] head_idx[32768];
    logic [11:0] tail_idx[32768];
    vpg_pkg::pt_t pts    [4096];
    logic [11:0] nxt     [4096];
    bit          has_nxt [4096];
    logic [14:0] keys    [4096];
    int unsigned n_pts, n_keys, key_pos;
    bit          cur_ok;
    logic [11:0] cur;
    vpg_pkg::res_t pending[$];
    int          errors, reported, checked, kept_cnt, full_cnt, got_pts, lasts;

    function void wipe();
      foreach (head_ok[i]) head_ok[i] = 1'b0;
      n_pts = 0;
      n_keys = 0;
      key_pos = 0;
      cur_ok = 1'b0;
    endfunction

    function void fail(string what, vpg_pkg::res_t e, vpg_pkg::res_t g);
      errors++;
      if (reported < 10) begin
        reported++;
        $display({"[%0t] %s: exp v=%0b b=%0b x=%0d y=%0d z=%0d cam=%0d dep=%0d",
                  " col=%0d row=%0d last=%0b kept=%0b full=%0b"},
                 $time, what, e.valid, e.pt.batch, e.pt.x, e.pt.y, e.pt.z, e.pt.cam,
                 e.pt.depth, e.pt.col, e.pt.row, e.last, e.kept, e.full);
        $display({"          got v=%0b b=%0b x=%0d y=%0d z=%0d cam=%0d dep=%0d",
                  " col=%0d row=%0d last=%0b kept=%0b full=%0b"},
                 g.valid, g.pt.batch, g.pt.x, g.pt.y, g.pt.z, g.pt.cam,
                 g.pt.depth, g.pt.col, g.pt.row, g.last, g.kept, g.full);
      end
    endfunction

    function void note_item(point_req_t it);
      vpg_pkg::res_t r;
      int   lx, ly, lz;
      int   k;
      vpg_pkg::pt_t p;
      r = '0;
      lx = (gx > 64) ? 64 : int'(gx);
      ly = (gy > 64) ? 64 : int'(gy);
      lz = (gz > 4) ? 4 : int'(gz);
      case (it.rq)
        vpg_pkg::REQ_ADD: begin
          if (!it.cx[15] && it.cx < lx && !it.cy[15] && it.cy < ly &&
              !it.cz[15] && it.cz < lz) begin
            if (n_pts >= 4096) begin
              r.full = 1'b1;
              full_cnt++;
            end else begin
              k = ((int'(it.b) * 4 + int'(it.cz)) * 64 + int'(it.cy)) * 64 + int'(it.cx);
              p.batch = it.b;
              p.x = it.cx[5:0];
              p.y = it.cy[5:0];
              p.z = it.cz[1:0];
              p.cam = it.cam;
              p.depth = it.dep;
              p.col = it.col;
              p.row = it.row;
              pts[n_pts] = p;
              has_nxt[n_pts] = 1'b0;
              if (!head_ok[k]) begin
                head_ok[k] = 1'b1;
                head_idx[k] = 12'(n_pts);
                keys[n_keys] = 15'(k);
                n_keys++;
              end else begin
                has_nxt[tail_idx[k]] = 1'b1;
                nxt[tail_idx[k]] = 12'(n_pts);
              end
              tail_idx[k] = 12'(n_pts);
              n_pts++;
              r.kept = 1'b1;
              kept_cnt++;
            end
          end
        end
        vpg_pkg::REQ_READ: begin
          if (cur_ok || key_pos < n_keys) begin
            if (!cur_ok) begin
              cur = head_idx[keys[key_pos]];
              cur_ok = 1'b1;
            end
            r.valid = 1'b1;
            r.pt = pts[cur];
            if (has_nxt[cur]) begin
              cur = nxt[cur];
            end else begin
              cur_ok = 1'b0;
              key_pos++;
              r.last = (key_pos >= n_keys);
            end
          end
        end
        vpg_pkg::REQ_CLEAR: wipe();
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check(vpg_pkg::res_t got);
      vpg_pkg::res_t e;
      checked++;
      if (pending.size() == 0) begin
        fail("result with nothing expected", '0, got);
        return;
      end
      e = pending.pop_front();
      if (got.valid !== e.valid || got.pt !== e.pt || got.last !== e.last ||
          got.kept !== e.kept || got.full !== e.full)
        fail("result mismatch", e, got);
      if (got.valid === 1'b1) got_pts++;
      if (got.last === 1'b1) lasts++;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid_i = 0;
  logic        req_stall_o;
  logic [1:0]  req_type_i = '0;
  logic        batch_index_i = 0;
  logic [2:0]  camera_index_i = '0;
  logic [6:0]  depth_bin_i = '0;
  logic [5:0]  pixel_row_i = '0;
  logic [6:0]  pixel_col_i = '0;
  logic [15:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 0;
  logic        out_valid_o, out_batch_o, out_last_o, point_kept_o, store_full_o;
  logic [5:0]  out_x_o, out_y_o, out_row_o;
  logic [1:0]  out_z_o;
  logic [2:0]  out_camera_o;
  logic [6:0]  out_depth_o, out_col_o;

  grouper_scoreboard sb = new();
  int send_pct, recv_pct;
  int hold_left;
  int n_items;
  int quiet;

  voxel_point_grouper dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o), .req_type_i(req_type_i),
    .batch_index_i(batch_index_i), .camera_index_i(camera_index_i),
    .depth_bin_i(depth_bin_i), .pixel_row_i(pixel_row_i), .pixel_col_i(pixel_col_i),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .coord_z_i(coord_z_i),
    .res_valid_o(res_valid_o), .res_stall_i(res_stall_i), .out_valid_o(out_valid_o),
    .out_batch_o(out_batch_o), .out_x_o(out_x_o), .out_y_o(out_y_o), .out_z_o(out_z_o),
    .out_camera_o(out_camera_o), .out_depth_o(out_depth_o), .out_col_o(out_col_o),
    .out_row_o(out_row_o), .out_last_o(out_last_o), .point_kept_o(point_kept_o),
    .store_full_o(store_full_o)
  );

  always #5 clk_i = ~clk_i;

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i)
      sb.check('{valid: out_valid_o,
                 pt: '{batch: out_batch_o, x: out_x_o, y: out_y_o, z: out_z_o,
                       cam: out_camera_o, depth: out_depth_o, col: out_col_o,
                       row: out_row_o},
                 last: out_last_o, kept: point_kept_o, full: store_full_o});
    if (hold_left > 0) begin
      res_stall_i <= 1'b1;
      hold_left--;
    end else begin
      res_stall_i <= ($urandom_range(99, 0) < recv_pct);
    end
  end

  // watchdog: cycles with no handshake of any kind (reset sweep included)
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (res_valid_o && !res_stall_i) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("voxel_point_grouper_tb: errors");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      vpg_pkg::REG_GRID_X: sb.gx = val[6:0];
      vpg_pkg::REG_GRID_Y: sb.gy = val[6:0];
      default:             sb.gz = val[2:0];
    endcase
  endtask

  task automatic set_grid(int x, int y, int z);
    apb_write(vpg_pkg::REG_GRID_X, x);
    apb_write(vpg_pkg::REG_GRID_Y, y);
    apb_write(vpg_pkg::REG_GRID_Z, z);
  endtask

  task automatic send(point_req_t it);
    while ($urandom_range(99, 0) < send_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= it.rq;
    batch_index_i <= it.b;
    camera_index_i <= it.cam;
    depth_bin_i <= it.dep;
    pixel_row_i <= it.row;
    pixel_col_i <= it.col;
    coord_x_i <= it.cx;
    coord_y_i <= it.cy;
    coord_z_i <= it.cz;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_item(it);
    n_items++;
  endtask

  // wait out every pending result, then a margin for the block to settle
  task automatic drain_all();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic point_req_t mk(vpg_pkg::req_e rq, int x, int y, int z,
                                    logic b = 1'b0);
    point_req_t it;
    it.rq = rq;
    it.b = b;
    it.cam = 3'($urandom);
    it.dep = 7'($urandom);
    it.row = 6'($urandom);
    it.col = 7'($urandom);
    it.cx = 16'(x);
    it.cy = 16'(y);
    it.cz = 16'(z);
    return it;
  endfunction

  function automatic point_req_t in_grid_add();
    int lx, ly, lz;
    lx = (sb.gx > 64) ? 64 : int'(sb.gx);
    ly = (sb.gy > 64) ? 64 : int'(sb.gy);
    lz = (sb.gz > 4) ? 4 : int'(sb.gz);
    return mk(vpg_pkg::REQ_ADD,
              (lx == 0) ? $urandom_range(3, 0) : $urandom_range(lx - 1, 0),
              (ly == 0) ? $urandom_range(3, 0) : $urandom_range(ly - 1, 0),
              (lz == 0) ? $urandom_range(3, 0) : $urandom_range(lz - 1, 0),
              1'($urandom));
  endfunction

  function automatic point_req_t rand_item();
    int sel;
    point_req_t it;
    sel = $urandom_range(99, 0);
    if (sel < 45) begin
      it = in_grid_add();
    end else if (sel < 90) begin
      it = mk(vpg_pkg::REQ_READ, $urandom, $urandom, $urandom, 1'($urandom));
    end else if (sel < 95) begin
      it = mk(vpg_pkg::REQ_ADD, $urandom, $urandom, $urandom, 1'($urandom));
    end else if (sel < 97) begin
      it = mk(vpg_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, 1'($urandom));
    end else begin
      it = mk(vpg_pkg::REQ_NOP, $urandom, $urandom, $urandom, 1'($urandom));
    end
    return it;
  endfunction

  task automatic random_run(int n);
    repeat (n) send(rand_item());
  endtask

  initial begin
    point_req_t it;
    send_pct = 26;
    recv_pct = 76;
    hold_left = 0;
    n_items = 0;
    quiet = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_grid(int'(vpg_pkg::GRID_X_RST), int'(vpg_pkg::GRID_Y_RST),
             int'(vpg_pkg::GRID_Z_RST));
    // directed: empty read, extremes, drops, same voxel twice, add while draining
    send(mk(vpg_pkg::REQ_READ, 0, 0, 0));
    it = mk(vpg_pkg::REQ_ADD, 63, 63, 3, 1'b1);
    it.cam = '1;
    it.dep = '1;
    it.row = '1;
    it.col = '1;
    send(it);
    it = mk(vpg_pkg::REQ_ADD, 0, 0, 0, 1'b0);
    it.cam = '0;
    it.dep = '0;
    it.row = '0;
    it.col = '0;
    send(it);
    send(mk(vpg_pkg::REQ_ADD, 16'hFFFF, 0, 0));
    send(mk(vpg_pkg::REQ_ADD, 0, 16'h8000, 0));
    send(mk(vpg_pkg::REQ_ADD, 0, 0, 16'hFFFF));
    send(mk(vpg_pkg::REQ_ADD, 64, 0, 0));
    send(mk(vpg_pkg::REQ_ADD, 0, 64, 0));
    send(mk(vpg_pkg::REQ_ADD, 0, 0, 4));
    send(mk(vpg_pkg::REQ_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send(mk(vpg_pkg::REQ_ADD, 63, 63, 3, 1'b1));
    send(mk(vpg_pkg::REQ_NOP, 5, 5, 1, 1'b1));
    send(mk(vpg_pkg::REQ_READ, 0, 0, 0));
    send(mk(vpg_pkg::REQ_ADD, 63, 63, 3, 1'b1));
    send(mk(vpg_pkg::REQ_ADD, 5, 6, 2, 1'b0));
    repeat (5) send(mk(vpg_pkg::REQ_READ, 0, 0, 0));
    send(mk(vpg_pkg::REQ_ADD, 1, 1, 1));
    send(mk(vpg_pkg::REQ_CLEAR, 0, 0, 0));
    send(mk(vpg_pkg::REQ_READ, 0, 0, 0));

    random_run(150);
    // long result stall while items keep coming
    hold_left = 300;
    random_run(150);
    drain_all();

    set_grid(3, 2, 1);
    random_run(200);
    drain_all();

    send_pct = 76;
    recv_pct = 26;
    set_grid(0, 127, 7);
    random_run(60);
    drain_all();
    set_grid(127, 1, 0);
    random_run(60);
    drain_all();
    set_grid(5, 4, 2);
    random_run(150);
    drain_all();
    random_run(150);
    drain_all();

    send_pct = 0;
    recv_pct = 0;
    set_grid(64, 64, 4);
    random_run(200);
    // clear, read the empty set past its end, then clear again
    send(mk(vpg_pkg::REQ_CLEAR, 0, 0, 0));
    repeat (20) send(mk(vpg_pkg::REQ_READ, 0, 0, 0));
    send(mk(vpg_pkg::REQ_CLEAR, 0, 0, 0));
    random_run(40);
    drain_all();

    $display("%0d items sent over six grid settings, %0d results checked",
             n_items, sb.checked);
    $display("%0d points kept, %0d dropped on a full store, %0d read back, %0d last flags",
             sb.kept_cnt, sb.full_cnt, sb.got_pts, sb.lasts);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("voxel_point_grouper_tb: clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("voxel_point_grouper_tb: errors");
    end
    $finish;
  end

endmodule
